/* rtl/timestamped_spike_delay_queue_top_defines.svh */
// Assertion macros used by the spike delay queue datapath.
`ifndef TIMESTAMPED_SPIKE_DELAY_QUEUE_TOP_DEFINES_SVH
`define TIMESTAMPED_SPIKE_DELAY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TSDQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define TSDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tsdq_pkg.sv */
// Package: types and constants of the spike delay queue.
`default_nettype none
package tsdq_pkg;

  localparam int WEIGHT_W  = 13;
  localparam int INDEX_LSB = 16;
  localparam int INDEX_W   = 11;
  localparam int DUE_W     = 32;
  localparam int ENTRY_W   = DUE_W + INDEX_W;
  localparam int ADDR_W    = 4;

  localparam logic FUNC_WORD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [1:0] REG_DELAY = 2'd0;
  localparam logic [1:0] REG_CHIP  = 2'd1;
  localparam logic [1:0] REG_CORE  = 2'd2;
  localparam logic [1:0] REG_POP   = 2'd3;

  typedef struct packed {
    logic        func;
    logic [31:0] synaptic_word;
    logic [31:0] now_time;
  } item_t;

  typedef struct packed {
    logic [31:0] spike_key;
    logic        dropped;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0]        delay_time;
    logic [15:0]        chip_ident;
    logic [4:0]         core_ident;
    logic [INDEX_W-1:0] population_base;
  } cfg_t;

  typedef struct packed {
    logic enq;
    logic drop;
    logic load_now;
    logic pop;
    logic emit;
    logic last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic weight_nz;
    logic full;
    logic due_ok;
    logic pend_valid;
  } ctrl_stat_t;

endpackage
`default_nettype wire

/* rtl/tsdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tsdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/tsdq_regs.sv */
// APB configuration registers.
`default_nettype none
module tsdq_regs
  import tsdq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr;
  logic [1:0] sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (sel)
        REG_DELAY: cfg.delay_time      <= pwdata;
        REG_CHIP:  cfg.chip_ident      <= pwdata[15:0];
        REG_CORE:  cfg.core_ident      <= pwdata[4:0];
        REG_POP:   cfg.population_base <= pwdata[INDEX_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_DELAY: prdata = cfg.delay_time;
      REG_CHIP:  prdata = {16'd0, cfg.chip_ident};
      REG_CORE:  prdata = {27'd0, cfg.core_ident};
      REG_POP:   prdata = {{(32-INDEX_W){1'b0}}, cfg.population_base};
      default:   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/tsdq_ctrl.sv */
// Controller: accepts commands and sequences the dispatch loop.
`default_nettype none
module tsdq_ctrl
  import tsdq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       func,
  input  wire ctrl_stat_t stat,
  output ctrl_cmd_t       cmd,
  output logic            busy
);

  typedef enum logic [1:0] {
    IDLE  = 2'b01,
    CHECK = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   word_hit;

  assign busy     = (state == CHECK);
  assign accept   = start && (state == IDLE);
  assign word_hit = accept && (func == FUNC_WORD) && stat.weight_nz;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cmd.enq        = word_hit && !stat.full;
    cmd.drop       = word_hit && stat.full;
    cmd.load_now   = accept && (func == FUNC_TICK);
    unique case (state)
      IDLE: begin
        if (cmd.load_now) begin
          state_next = CHECK;
        end
      end
      CHECK: begin
        cmd.pop  = stat.due_ok;
        cmd.emit = stat.pend_valid;
        cmd.last = !stat.due_ok;
        if (!stat.due_ok) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/tsdq_dp.sv */
// Datapath: ring pointers, entry RAM, pending key and result register.
`default_nettype none
`include "timestamped_spike_delay_queue_top_defines.svh"
module tsdq_dp
  import tsdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire item_t     item,
  input  wire cfg_t      cfg,
  input  wire ctrl_cmd_t cmd,
  output ctrl_stat_t     stat,
  output result_t        result,
  output logic           result_strobe
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  logic [PW-1:0]      head, tail, head_inc, tail_inc, head_next;
  logic               empty;
  logic [31:0]        now_q;
  logic               pend_valid;
  logic [31:0]        pend_key;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic [DUE_W-1:0]   rd_due;
  logic [INDEX_W-1:0] rd_index;
  logic [31:0]        key;

  assign head_inc  = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign tail_inc  = (tail == LAST_SLOT) ? '0 : tail + 1'b1;
  assign head_next = cmd.pop ? head_inc : head;

  assign wdata = {item.now_time + cfg.delay_time,
                  item.synaptic_word[INDEX_LSB +: INDEX_W]};

  tsdq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.enq),
    .waddr(tail),
    .wdata(wdata),
    .raddr(head_next),
    .rdata(rdata)
  );

  assign {rd_due, rd_index} = rdata;
  assign key = {cfg.chip_ident, cfg.core_ident, cfg.population_base | rd_index};

  assign stat.weight_nz  = |item.synaptic_word[WEIGHT_W-1:0];
  assign stat.full       = !empty && (head == tail);
  assign stat.due_ok     = !empty && (rd_due <= now_q);
  assign stat.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      tail          <= '0;
      empty         <= 1'b1;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      head <= head_next;
      if (cmd.enq) begin
        tail  <= tail_inc;
        empty <= 1'b0;
      end else if (cmd.pop && (head_inc == tail)) begin
        empty <= 1'b1;
      end
      if (cmd.pop) begin
        pend_valid <= 1'b1;
      end else if (cmd.emit) begin
        pend_valid <= 1'b0;
      end
      result_strobe <= cmd.emit || cmd.drop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_now) begin
      now_q <= item.now_time;
    end
    if (cmd.pop) begin
      pend_key <= key;
    end
    if (cmd.drop) begin
      result <= '{spike_key: '0, dropped: 1'b1, last: 1'b1};
    end else begin
      result <= '{spike_key: pend_key, dropped: 1'b0, last: cmd.last};
    end
  end

  `TSDQ_ASSERT_NOW(a_pop_nonempty, clk, rst, cmd.pop, !empty, "pop from empty queue")
  `TSDQ_ASSERT_NOW(a_enq_not_full, clk, rst, cmd.enq, !stat.full, "enqueue into full queue")
  `TSDQ_ASSERT_NEXT(a_last_clears, clk, rst, cmd.emit && cmd.last, !pend_valid,
                    "pending key left after last beat")
  `TSDQ_ASSERT_NOW(a_emit_excl, clk, rst, cmd.emit, !cmd.drop && !cmd.enq,
                   "dispatch beat overlaps word command")

endmodule
`default_nettype wire

/* rtl/timestamped_spike_delay_queue_top.sv */
// Top level of the timestamped spike delay queue.
// Usage:
//   Command channel: drive item and raise start; the item is taken at an edge
//   where start is high and busy is low. Config via the APB port, only idle.
//   Word items (func 0) with a nonzero weight append (now_time + delay_time,
//   index) to the ring and never raise busy. A word that finds the ring full
//   yields one beat with dropped and last set, in the cycle after acceptance.
//   Tick items (func 1) raise busy while due entries are popped, until the
//   head is not due or the ring is empty; one head entry is compared and
//   popped per cycle, the RAM read of the next head overlapping the compare.
//   Key beats follow on result/result_strobe behind their pops, through the
//   pending key and result registers; the final one, with last, comes in the
//   first cycle with busy low. A tick that pops nothing yields no beat.
//   Each beat is valid for exactly one cycle; the receiver cannot stall.
//   Reset (synchronous, rst high) empties the ring, idles the controller and
//   zeroes the config; the entry RAM is not cleared and needs no clearing pass.
`default_nettype none
module timestamped_spike_delay_queue_top
  import tsdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire item_t             item,
  output result_t                result,
  output logic                   result_strobe,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  tsdq_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  tsdq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .func (item.func),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  tsdq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_strobe(result_strobe)
  );

endmodule
`default_nettype wire
